@@ rtl/core/cham_pkg.sv @@
// Shared types, constants and helper functions for the CHAM-128/128 encrypt core.
package cham_pkg;

   localparam int ROUND_COUNT = 80;
   localparam int WORD_W      = 32;
   localparam int RK_COUNT    = 8;
   localparam int RND_W       = (ROUND_COUNT > 2) ? $clog2(ROUND_COUNT) : 1;
   localparam int CSR_IDX_W   = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] KEY_WORD0_IDX = 8'd0;
   localparam logic [CSR_IDX_W-1:0] KEY_WORD1_IDX = 8'd1;
   localparam logic [CSR_IDX_W-1:0] KEY_WORD2_IDX = 8'd2;
   localparam logic [CSR_IDX_W-1:0] KEY_WORD3_IDX = 8'd3;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      word_type block_word0;
      word_type block_word1;
      word_type block_word2;
      word_type block_word3;
   } req_type;

   typedef struct packed {
      word_type cipher_word0;
      word_type cipher_word1;
      word_type cipher_word2;
      word_type cipher_word3;
   } rsp_type;

   typedef struct packed {
      word_type x0;
      word_type x1;
      word_type x2;
      word_type x3;
   } state_type;

   typedef word_type [RK_COUNT-1:0] rk_type;

   function automatic word_type rol1(input word_type v);
      return {v[WORD_W-2:0], v[WORD_W-1]};
   endfunction

   function automatic word_type rol8(input word_type v);
      return {v[WORD_W-9:0], v[WORD_W-1:WORD_W-8]};
   endfunction

   function automatic word_type rol11(input word_type v);
      return {v[WORD_W-12:0], v[WORD_W-1:WORD_W-11]};
   endfunction

   // round key taken into slot i
   function automatic word_type rk_lo(input word_type k);
      return k ^ rol1(k) ^ rol8(k);
   endfunction

   // round key taken into slot (i+4)^1
   function automatic word_type rk_hi(input word_type k);
      return k ^ rol1(k) ^ rol11(k);
   endfunction

endpackage

@@ rtl/core/cham_key_sched.sv @@
// Key registers and round key expansion, updated on each key word write.
module cham_key_sched (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [cham_pkg::CSR_IDX_W-1:0]      csr_index,
   input  cham_pkg::word_type                  csr_wdata,
   output cham_pkg::rk_type                    rk
);

   cham_pkg::rk_type rk_ff;
   cham_pkg::rk_type rk_in;
   cham_pkg::word_type lo_w;
   cham_pkg::word_type hi_w;

   assign lo_w = cham_pkg::rk_lo(csr_wdata);
   assign hi_w = cham_pkg::rk_hi(csr_wdata);

   always_comb begin
      rk_in = rk_ff;
      if (csr_valid) begin
         case (csr_index)
            cham_pkg::KEY_WORD0_IDX: begin
               rk_in[0] = lo_w;
               rk_in[5] = hi_w;
            end
            cham_pkg::KEY_WORD1_IDX: begin
               rk_in[1] = lo_w;
               rk_in[4] = hi_w;
            end
            cham_pkg::KEY_WORD2_IDX: begin
               rk_in[2] = lo_w;
               rk_in[7] = hi_w;
            end
            cham_pkg::KEY_WORD3_IDX: begin
               rk_in[3] = lo_w;
               rk_in[6] = hi_w;
            end
            default: begin
               rk_in = rk_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rk_ff <= '0;
      end else begin
         rk_ff <= rk_in;
      end
   end

   assign rk = rk_ff;

endmodule

@@ rtl/core/cham_round.sv @@
// One registered CHAM round: xor round number, add keyed word, rotate, shift.
module cham_round (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_vld,
   input  cham_pkg::state_type             in_st,
   input  logic [cham_pkg::RND_W-1:0]      rnd,
   input  cham_pkg::word_type              rk,
   output logic                            out_vld,
   output cham_pkg::state_type             out_st
);

   logic                vld_ff;
   cham_pkg::state_type st_ff;
   cham_pkg::state_type st_in;
   cham_pkg::word_type  a_w;
   cham_pkg::word_type  b_w;
   cham_pkg::word_type  sum_w;
   cham_pkg::word_type  t_w;

   always_comb begin
      a_w   = in_st.x0 ^ cham_pkg::WORD_W'(rnd);
      // even rounds rotate x1 by 1 and the sum by 8; odd rounds the other way
      b_w   = (rnd[0] ? cham_pkg::rol8(in_st.x1) : cham_pkg::rol1(in_st.x1)) ^ rk;
      sum_w = a_w + b_w;
      t_w   = rnd[0] ? cham_pkg::rol1(sum_w) : cham_pkg::rol8(sum_w);
      st_in = '{x0: in_st.x1, x1: in_st.x2, x2: in_st.x3, x3: t_w};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      st_ff <= st_in;
   end

   assign out_vld = vld_ff;
   assign out_st  = st_ff;

endmodule

@@ rtl/core/cham_block_encrypt.sv @@
// CHAM-128/128 encrypt core: fully unrolled pipeline, one round per stage.
// Throughput: one word per cycle outside reset; each round stage holds one 32-bit add.
// busy is high only during reset; the result side cannot be held off, so it
// never stalls. Reset (synchronous, active high) clears stage valid bits and
// the key, which then reads as all zeros.
module cham_block_encrypt (
   input  logic                            clock,
   input  logic                            reset,
   // request
   input  logic                            start,
   output logic                            busy,
   input  cham_pkg::req_type               req_data,
   // response
   output logic                            rsp_strobe,
   output cham_pkg::rsp_type               rsp_data,
   // key write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cham_pkg::CSR_IDX_W-1:0]  csr_index,
   input  cham_pkg::word_type              csr_wdata
);

   localparam int NR = cham_pkg::ROUND_COUNT;

   logic                vld_w [0:NR];
   cham_pkg::state_type st_w  [0:NR];
   cham_pkg::rk_type    rk_w;

   // Pipeline never backs up, so the request side is open outside reset.
   assign busy      = reset;
   assign csr_ready = 1'b1;

   // Round keys are rebuilt at write time; keys must only change while idle, which the core does not enforce.
   cham_key_sched u_key (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rk        (rk_w)
   );

   // Stage 0 input is the request word itself.
   assign vld_w[0] = start & ~busy;
   assign st_w[0]  = '{x0: req_data.block_word0, x1: req_data.block_word1,
                       x2: req_data.block_word2, x3: req_data.block_word3};

   // One stage per round; round number and key slot are fixed per stage.
   for (genvar r = 0; r < NR; r++) begin : g_rnd
      logic [cham_pkg::RND_W-1:0] rnd_c;
      assign rnd_c = cham_pkg::RND_W'(r);

      cham_round u_round (
         .clock   (clock),
         .reset   (reset),
         .in_vld  (vld_w[r]),
         .in_st   (st_w[r]),
         .rnd     (rnd_c),
         .rk      (rk_w[r % cham_pkg::RK_COUNT]),
         .out_vld (vld_w[r+1]),
         .out_st  (st_w[r+1])
      );
   end

   assign rsp_strobe = vld_w[NR];
   assign rsp_data   = '{cipher_word0: st_w[NR].x0, cipher_word1: st_w[NR].x1,
                         cipher_word2: st_w[NR].x2, cipher_word3: st_w[NR].x3};

   // An accepted word always occupies the first stage next cycle.
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> vld_w[1])
      else $error("accepted word missing from first stage");

   // Stage valid moves down one stage per cycle.
   a_flow: assert property (@(posedge clock) disable iff (reset)
      vld_w[1] |-> ##(NR-1) rsp_strobe)
      else $error("word lost in round pipeline");

   // Writing key word 0 sets both of its round key slots.
   a_key0: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready && csr_index == cham_pkg::KEY_WORD0_IDX) |=>
      (rk_w[0] == cham_pkg::rk_lo($past(csr_wdata)) &&
       rk_w[5] == cham_pkg::rk_hi($past(csr_wdata))))
      else $error("round keys for key word 0 wrong");

   // Nothing comes out the cycle after reset.
   a_rst: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("result strobe right after reset");

endmodule

@@ tb/cham_block_encrypt_tb.sv @@
// Self-checking testbench for the CHAM-128/128 encrypt core: directed and random blocks.
module cham_block_encrypt_tb;

   // Generous ceiling: 719 words with mostly short gaps, a handful of key
   // phases each draining the 80-stage pipe, reset, and plenty of slack.
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_COUNT   = 8;
   localparam int PHASE_WORDS   = 88;
   localparam int SETTLE_CYCLES = 8;

   // Keeps its own copy of the key, predicts the ciphertext of each
   // accepted word and matches results in order.
   class cipher_scoreboard;
      cham_pkg::word_type key_words [4];
      cham_pkg::rsp_type  expected_ciphers [$];
      int                 fail_count;

      function new();
         foreach (key_words[i]) key_words[i] = '0;
         fail_count = 0;
      endfunction

      task report(input string msg);
         $display("ERROR: %s", msg);
         fail_count++;
      endtask

      function int pending();
         return expected_ciphers.size();
      endfunction

      // Writes beyond the last key word are dropped by the block.
      function void note_key(input logic [cham_pkg::CSR_IDX_W-1:0] idx,
                             input cham_pkg::word_type value);
         if (idx <= cham_pkg::KEY_WORD3_IDX) key_words[idx[1:0]] = value;
      endfunction

      function cham_pkg::word_type rotl(input cham_pkg::word_type v,
                                        input int unsigned s);
         return (v << s) | (v >> (cham_pkg::WORD_W - s));
      endfunction

      function cham_pkg::rsp_type encrypt_block(input cham_pkg::req_type blk);
         cham_pkg::word_type round_keys [cham_pkg::RK_COUNT];
         cham_pkg::word_type x0, x1, x2, x3, t, sum;
         cham_pkg::rsp_type  ct;
         // slot i gets the rol8 form, slot (i+4)^1 the rol11 form
         for (int i = 0; i < 4; i++) begin
            round_keys[i]           = key_words[i] ^ rotl(key_words[i], 1)
                                      ^ rotl(key_words[i], 8);
            round_keys[(i + 4) ^ 1] = key_words[i] ^ rotl(key_words[i], 1)
                                      ^ rotl(key_words[i], 11);
         end
         x0 = blk.block_word0;
         x1 = blk.block_word1;
         x2 = blk.block_word2;
         x3 = blk.block_word3;
         for (int r = 0; r < cham_pkg::ROUND_COUNT; r++) begin
            if (r % 2 == 0) begin
               sum = (x0 ^ cham_pkg::word_type'(r))
                     + (rotl(x1, 1) ^ round_keys[r % cham_pkg::RK_COUNT]);
               t   = rotl(sum, 8);
            end else begin
               sum = (x0 ^ cham_pkg::word_type'(r))
                     + (rotl(x1, 8) ^ round_keys[r % cham_pkg::RK_COUNT]);
               t   = rotl(sum, 1);
            end
            x0 = x1;
            x1 = x2;
            x2 = x3;
            x3 = t;
         end
         ct.cipher_word0 = x0;
         ct.cipher_word1 = x1;
         ct.cipher_word2 = x2;
         ct.cipher_word3 = x3;
         return ct;
      endfunction

      function void note_block(input cham_pkg::req_type blk);
         expected_ciphers.push_back(encrypt_block(blk));
      endfunction

      task check_cipher(input cham_pkg::rsp_type got);
         cham_pkg::rsp_type want;
         if (expected_ciphers.size() == 0) begin
            report($sformatf("unexpected result %h", got));
            return;
         end
         want = expected_ciphers.pop_front();
         if (got.cipher_word0 !== want.cipher_word0)
            report($sformatf("cipher_word0 got %h expected %h",
                             got.cipher_word0, want.cipher_word0));
         if (got.cipher_word1 !== want.cipher_word1)
            report($sformatf("cipher_word1 got %h expected %h",
                             got.cipher_word1, want.cipher_word1));
         if (got.cipher_word2 !== want.cipher_word2)
            report($sformatf("cipher_word2 got %h expected %h",
                             got.cipher_word2, want.cipher_word2));
         if (got.cipher_word3 !== want.cipher_word3)
            report($sformatf("cipher_word3 got %h expected %h",
                             got.cipher_word3, want.cipher_word3));
      endtask
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           busy;
   cham_pkg::req_type              req_data = '0;
   logic                           rsp_strobe;
   cham_pkg::rsp_type              rsp_data;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [cham_pkg::CSR_IDX_W-1:0] csr_index = '0;
   cham_pkg::word_type             csr_wdata = '0;

   cipher_scoreboard sb;
   int               cycle_count = 0;
   bit               gaps_off = 1'b0;   // set for back-to-back stretches

   cham_block_encrypt i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Watchdog: a hung pipe or lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Results cannot be held off, so every strobe is taken at its edge.
   // Values read here are the pre-edge ones, free of update ordering.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_cipher(rsp_data);
   end

   // Mostly none or short, now and then a long pause.
   function automatic int next_gap();
      int pick;
      if (gaps_off) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // Random word with extra weight on the all-zero, all-one and one-hot corners.
   function automatic cham_pkg::word_type rand_word();
      int pick;
      pick = $urandom_range(0, 15);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      if (pick == 2)
         return cham_pkg::word_type'(1) << $urandom_range(0, cham_pkg::WORD_W - 1);
      return $urandom;
   endfunction

   // Holds start until the core takes the word; start is only dropped when a
   // gap follows, so back-to-back words never see start toggled in one step.
   task automatic send_block(input cham_pkg::req_type blk);
      int gap;
      start    <= 1'b1;
      req_data <= blk;
      do @(posedge clock); while (busy);
      sb.note_block(blk);
      gap = next_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_words(input cham_pkg::word_type w0, input cham_pkg::word_type w1,
                             input cham_pkg::word_type w2, input cham_pkg::word_type w3);
      cham_pkg::req_type blk;
      blk.block_word0 = w0;
      blk.block_word1 = w1;
      blk.block_word2 = w2;
      blk.block_word3 = w3;
      send_block(blk);
   endtask

   // Key write on the CSR channel; same hold-until-taken pattern as start.
   task automatic write_key(input logic [cham_pkg::CSR_IDX_W-1:0] idx,
                            input cham_pkg::word_type value);
      int gap;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      sb.note_key(idx, value);
      gap = next_gap();
      if (gap > 0) begin
         csr_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Random index past the last key word.
   function automatic logic [cham_pkg::CSR_IDX_W-1:0] stray_index();
      return cham_pkg::CSR_IDX_W'($urandom_range(int'(cham_pkg::KEY_WORD3_IDX) + 1, 255));
   endfunction

   // Writes all four key words, sometimes with a stray out-of-range write
   // mixed in that must leave the key untouched.
   task automatic load_key(input cham_pkg::word_type k0, input cham_pkg::word_type k1,
                           input cham_pkg::word_type k2, input cham_pkg::word_type k3);
      write_key(cham_pkg::KEY_WORD0_IDX, k0);
      if ($urandom_range(0, 1) == 1)
         write_key(stray_index(), rand_word());
      write_key(cham_pkg::KEY_WORD1_IDX, k1);
      write_key(cham_pkg::KEY_WORD2_IDX, k2);
      write_key(cham_pkg::KEY_WORD3_IDX, k3);
      if ($urandom_range(0, 1) == 1)
         write_key(stray_index(), rand_word());
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Key writes only go in once the pipe is empty; every word yields one
   // result, so an empty queue plus the settle wait is enough.
   task automatic drain_pipe();
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed, key still at its reset value of zero.
      send_words('0, '0, '0, '0);
      send_words('1, '1, '1, '1);
      send_words('1, '0, '0, '0);
      send_words('0, '0, '0, '1);
      send_words(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
      send_words(32'h8000_0000, 32'h0000_0001, 32'h8000_0000, 32'h0000_0001);
      drain_pipe();

      // Published key/plaintext pattern from the cipher description.
      load_key(32'h0302_0100, 32'h0706_0504, 32'h0b0a_0908, 32'h0f0e_0d0c);
      send_words(32'h3322_1100, 32'h7766_5544, 32'hbbaa_9988, 32'hffee_ddcc);
      send_words('0, '0, '0, '0);
      send_words('1, '1, '1, '1);
      drain_pipe();

      // All-ones key.
      load_key('1, '1, '1, '1);
      send_words('0, '0, '0, '0);
      send_words('1, '1, '1, '1);
      send_words(32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210);
      drain_pipe();

      // One key word set at a time: each one lands in two round-key slots.
      load_key(32'h8000_0001, '0, '0, '0);
      send_words(32'h1111_1111, 32'h2222_2222, 32'h3333_3333, 32'h4444_4444);
      drain_pipe();
      load_key('0, '0, '0, 32'h8000_0001);
      send_words(32'h1111_1111, 32'h2222_2222, 32'h3333_3333, 32'h4444_4444);
      send_words(32'hdead_beef, 32'hcafe_f00d, 32'h0bad_c0de, 32'hfeed_face);
      drain_pipe();

      // Random phases. The first puts the key back to zero, the last two
      // run back to back with no idling at all.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         gaps_off = (phase >= PHASE_COUNT - 2);
         if (phase == 0)
            load_key('0, '0, '0, '0);
         else
            load_key(rand_word(), rand_word(), rand_word(), rand_word());
         for (int n = 0; n < PHASE_WORDS; n++)
            send_words(rand_word(), rand_word(), rand_word(), rand_word());
         drain_pipe();
      end

      // Extra time after the last result so that any stray strobe shows up.
      repeat (cham_pkg::ROUND_COUNT + SETTLE_CYCLES) @(posedge clock);
      if (sb.fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
